// ----- rtl/utf8d_pkg.sv -----
`default_nettype none

package utf8d_pkg;

  localparam int unsigned CpWidth = 21;

  // Result status codes
  localparam logic [1:0] STATUS_VALID   = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_TRUNC   = 2'd2;

  // Lead length code for a byte that cannot open a sequence
  localparam logic [2:0] LEAD_BAD = 3'd0;

  // Code point limits
  localparam logic [CpWidth-1:0] CP_MAX      = 21'h10FFFF;
  localparam logic [CpWidth-1:0] CP_SURR_LO  = 21'h00D800;
  localparam logic [CpWidth-1:0] CP_SURR_HI  = 21'h00DFFF;
  localparam logic [CpWidth-1:0] CP_MIN_LEN2 = 21'h000080;
  localparam logic [CpWidth-1:0] CP_MIN_LEN3 = 21'h000800;
  localparam logic [CpWidth-1:0] CP_MIN_LEN4 = 21'h010000;

  // One classified byte as it travels from front end to back end
  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
    logic [2:0] lead_len;   // 1..4, or LEAD_BAD
    logic       is_cont;    // byte is 10xxxxxx
  } cls_t;

endpackage

`default_nettype wire

// ----- rtl/utf8d_front.sv -----
`default_nettype none

module utf8d_front (
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] data_byte_i,
  input  wire logic       end_of_stream_i,
  output logic            push_o,
  output utf8d_pkg::cls_t push_data_o,
  input  wire logic       full_i
);

  logic [2:0] lead_len;

  // Decode the lead pattern
  always_comb begin
    if (!data_byte_i[7]) begin
      lead_len = 3'd1;
    end else if (data_byte_i[7:5] == 3'b110) begin
      lead_len = 3'd2;
    end else if (data_byte_i[7:4] == 4'b1110) begin
      lead_len = 3'd3;
    end else if (data_byte_i[7:3] == 5'b11110) begin
      lead_len = 3'd4;
    end else begin
      lead_len = utf8d_pkg::LEAD_BAD;
    end
  end

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  assign push_data_o.data_byte     = data_byte_i;
  assign push_data_o.end_of_stream = end_of_stream_i;
  assign push_data_o.lead_len      = lead_len;
  assign push_data_o.is_cont       = (data_byte_i[7:6] == 2'b10);

endmodule

`default_nettype wire

// ----- rtl/utf8d_queue.sv -----
`default_nettype none

module utf8d_queue #(
  parameter int unsigned Depth = 4
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_i,
  input  wire utf8d_pkg::cls_t push_data_i,
  output logic                 full_o,
  input  wire logic            pop_i,
  output utf8d_pkg::cls_t      pop_data_o,
  output logic                 empty_o
);

  localparam int unsigned AddrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CountW = $clog2(Depth + 1);
  localparam logic [AddrW-1:0]  LastAddr = AddrW'(Depth - 1);
  localparam logic [CountW-1:0] Full     = CountW'(Depth);

  utf8d_pkg::cls_t   entries_q [Depth];
  logic [AddrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CountW-1:0] count_q, count_d;

  assign full_o     = (count_q == Full);
  assign empty_o    = (count_q == '0);
  assign pop_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (push_i && !pop_i) begin
      count_d = count_q + CountW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - CountW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/utf8d_back.sv -----
`default_nettype none

module utf8d_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire utf8d_pkg::cls_t pop_data_i,
  input  wire logic            empty_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic [20:0]          code_point_o,
  output logic [1:0]           status_o,
  output logic [2:0]           seq_length_o,
  output logic                 stream_done_o
);

  // Open sequence state
  logic [2:0]  exp_len_q, exp_len_d;
  logic [2:0]  seen_q, seen_d;
  logic [20:0] acc_q, acc_d;
  logic        badc_q, badc_d;

  // Result register
  logic        out_valid_q, out_valid_d;
  logic [20:0] cp_q;
  logic [1:0]  st_q;
  logic [2:0]  len_q;
  logic        done_q;

  // Result of the byte at the queue head
  logic        res_valid;
  logic [20:0] res_cp;
  logic [1:0]  res_st;
  logic [2:0]  res_len;
  logic        res_done;

  logic [7:0]  b;
  logic        eos;
  logic [2:0]  seen_n;
  logic [20:0] acc_n;
  logic        bad;

  assign b     = pop_data_i.data_byte;
  assign eos   = pop_data_i.end_of_stream;
  assign pop_o = !empty_i && (!out_valid_q || out_ready_i);

  always_comb begin
    exp_len_d = exp_len_q;
    seen_d    = seen_q;
    acc_d     = acc_q;
    badc_d    = badc_q;
    res_valid = 1'b0;
    res_cp    = '0;
    res_st    = utf8d_pkg::STATUS_VALID;
    res_len   = 3'd1;
    res_done  = eos;
    seen_n    = seen_q + 3'd1;
    acc_n     = {acc_q[14:0], b[5:0]};
    bad       = 1'b0;

    if (exp_len_q == 3'd0) begin
      if (pop_data_i.lead_len == 3'd1) begin
        res_valid = 1'b1;
        res_cp    = {13'd0, b};
      end else if (pop_data_i.lead_len == utf8d_pkg::LEAD_BAD) begin
        res_valid = 1'b1;
        res_st    = utf8d_pkg::STATUS_INVALID;
      end else if (eos) begin
        // Stream ends on a multi-byte lead
        res_valid = 1'b1;
        res_st    = utf8d_pkg::STATUS_TRUNC;
      end else begin
        exp_len_d = pop_data_i.lead_len;
        seen_d    = 3'd1;
        badc_d    = 1'b0;
        case (pop_data_i.lead_len)
          3'd2:    acc_d = {16'd0, b[4:0]};
          3'd3:    acc_d = {17'd0, b[3:0]};
          default: acc_d = {18'd0, b[2:0]};
        endcase
      end
    end else begin
      if (seen_n >= exp_len_q) begin
        bad = badc_q || !pop_data_i.is_cont;
        case (exp_len_q)
          3'd2: begin
            if (acc_n < utf8d_pkg::CP_MIN_LEN2) bad = 1'b1;
          end
          3'd3: begin
            if (acc_n < utf8d_pkg::CP_MIN_LEN3) bad = 1'b1;
            if (acc_n >= utf8d_pkg::CP_SURR_LO && acc_n <= utf8d_pkg::CP_SURR_HI) bad = 1'b1;
          end
          default: begin
            if (acc_n < utf8d_pkg::CP_MIN_LEN4 || acc_n > utf8d_pkg::CP_MAX) bad = 1'b1;
          end
        endcase
        res_valid = 1'b1;
        res_len   = exp_len_q;
        res_st    = bad ? utf8d_pkg::STATUS_INVALID : utf8d_pkg::STATUS_VALID;
        res_cp    = bad ? '0 : acc_n;
        exp_len_d = 3'd0;
        seen_d    = 3'd0;
        acc_d     = '0;
        badc_d    = 1'b0;
      end else if (eos) begin
        // Truncation outranks any bad continuation seen so far
        res_valid = 1'b1;
        res_len   = seen_n;
        res_st    = utf8d_pkg::STATUS_TRUNC;
        exp_len_d = 3'd0;
        seen_d    = 3'd0;
        acc_d     = '0;
        badc_d    = 1'b0;
      end else begin
        seen_d = seen_n;
        acc_d  = acc_n;
        badc_d = badc_q || !pop_data_i.is_cont;
      end
    end
  end

  always_comb begin
    if (out_valid_q && !out_ready_i) begin
      out_valid_d = 1'b1;
    end else begin
      out_valid_d = pop_o && res_valid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_len_q   <= '0;
      seen_q      <= '0;
      acc_q       <= '0;
      badc_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        exp_len_q <= exp_len_d;
        seen_q    <= seen_d;
        acc_q     <= acc_d;
        badc_q    <= badc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && res_valid) begin
      cp_q   <= res_cp;
      st_q   <= res_st;
      len_q  <= res_len;
      done_q <= res_done;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign code_point_o  = cp_q;
  assign status_o      = st_q;
  assign seq_length_o  = len_q;
  assign stream_done_o = done_q;

endmodule

`default_nettype wire

// ----- rtl/utf8_validating_decoder_top.sv -----
// Streaming UTF-8 decoder with strict validation. Bytes enter on the input
// channel, one per transaction, with end_of_stream_i marking the last byte of
// a stream. Each completed sequence (1 to 4 bytes) yields one result
// transaction: the code point and a status of valid (0), invalid (1) or
// truncated (2); code_point_o is zero unless the status is valid. Invalid
// covers bad lead bytes (reported at once, length 1), bad continuation bytes,
// overlong forms, surrogates and values above 0x10FFFF. A stream that ends
// inside a sequence gives a truncated result whose length counts the bytes
// taken; truncation wins over a bad continuation. Bytes that neither finish a
// sequence nor end the stream produce no result. Throughput is one byte per
// clock while the output is not stalled, set by the back end's sequence
// register, which advances once per byte. An accepted byte passes through
// the queue and then the result register before its result appears. A
// classifying front end feeds a QueueDepth-entry queue, so input and output
// stall independently; new bytes queue up while a result waits to be taken.
`default_nettype none

module utf8_validating_decoder_top #(
  parameter int unsigned QueueDepth = 4
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // byte input channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        end_of_stream_i,
  // result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [20:0]      code_point_o,
  output logic [1:0]       status_o,
  output logic [2:0]       seq_length_o,
  output logic             stream_done_o
);

  utf8d_pkg::cls_t push_data;
  utf8d_pkg::cls_t pop_data;
  logic            push;
  logic            pop;
  logic            full;
  logic            empty;

  // Front end: classify each byte (lead length, continuation form)
  utf8d_front u_front (
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .data_byte_i     (data_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  // Decoupling queue between front and back
  utf8d_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .empty_o     (empty)
  );

  // Back end: sequence assembly, validation and result register
  utf8d_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .pop_data_i    (pop_data),
    .empty_i       (empty),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .code_point_o  (code_point_o),
    .status_o      (status_o),
    .seq_length_o  (seq_length_o),
    .stream_done_o (stream_done_o)
  );

endmodule

`default_nettype wire

// ----- rtl/utf8d_checker.sv -----
`default_nettype none

module utf8d_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [20:0] code_point_i,
  input wire logic [1:0]  status_i,
  input wire logic [2:0]  seq_length_i,
  input wire logic        stream_done_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(code_point_i)
      && $stable(status_i) && $stable(seq_length_i) && $stable(stream_done_i))
    else $error("result changed while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i != utf8d_pkg::STATUS_VALID |-> code_point_i == '0)
    else $error("nonzero code point on non-valid status");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> seq_length_i >= 3'd1 && seq_length_i <= 3'd4)
    else $error("sequence length out of range");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == utf8d_pkg::STATUS_TRUNC |-> stream_done_i
      && seq_length_i <= 3'd3)
    else $error("truncated result not at end of stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == utf8d_pkg::STATUS_VALID |->
      code_point_i <= utf8d_pkg::CP_MAX
      && !(code_point_i >= utf8d_pkg::CP_SURR_LO && code_point_i <= utf8d_pkg::CP_SURR_HI))
    else $error("valid status on non-scalar value");

endmodule

bind utf8_validating_decoder_top utf8d_checker u_utf8d_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_valid_o),
  .out_ready_i   (out_ready_i),
  .code_point_i  (code_point_o),
  .status_i      (status_o),
  .seq_length_i  (seq_length_o),
  .stream_done_i (stream_done_o)
);

`default_nettype wire
